// ===== rtl/sensor_profile_classifier_macros.svh =====
// Assertion macros for the sensor profile classifier.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef SENSOR_PROFILE_CLASSIFIER_MACROS_SVH
`define SENSOR_PROFILE_CLASSIFIER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// Shared types, widths, register codes and helpers of the sensor profile classifier.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package spc_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 12;
  localparam int CNT_W     = 9;
  localparam int SUM_W     = 21;
  localparam int PROF_W    = 43;
  localparam int PCOUNT_W  = 3;
  localparam int PIDX_W    = 2;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;

  // Lowest-sample tracker starts at full scale.
  localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = '1;

  // Register codes (byte address is eight times the code).
  localparam logic [REG_IDX_W-1:0] REG_TRIGGER   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PCOUNT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PROFILE0  = 3'd3;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] TRIGGER_RESET   = 12'd2048;
  localparam logic [SAMPLE_W-1:0] TOLERANCE_RESET = 12'd40;

  // Measurement queue geometry.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  // One finished measurement, passed from the front end to the classifier.
  typedef struct packed {
    logic                ovf;
    logic [SAMPLE_W-1:0] min_val;
    logic [CNT_W-1:0]    min_pos;
    logic [CNT_W-1:0]    count;
    logic [SUM_W-1:0]    sum;
  } meas_t;

  // One classification result.
  typedef struct packed {
    logic                matched;
    logic [PIDX_W-1:0]   pidx;
    logic                ovf;
    logic [SAMPLE_W-1:0] min_val;
    logic [CNT_W-1:0]    min_pos;
    logic [CNT_W-1:0]    count;
  } res_t;

  // Classifier settings shared by all profiles.
  typedef struct packed {
    logic [SAMPLE_W-1:0] tol;
    logic [PCOUNT_W-1:0] count;
  } cls_cfg_t;

  // Decoded profile register.
  typedef struct packed {
    logic                has_hole;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] hole_min;
    logic [CNT_W-1:0]    hole_start;
    logic [CNT_W-1:0]    hole_stop;
  } prof_t;

  // Classifier sequencer states.
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_CMP  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  // Split a profile register into its fields.
  function automatic prof_t unpack_profile(input logic [PROF_W-1:0] p);
    prof_t f;
    f.has_hole   = p[0];
    f.avg        = p[12:1];
    f.hole_min   = p[24:13];
    f.hole_start = p[33:25];
    f.hole_stop  = p[42:34];
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spc_front.sv =====
// Front end: accepts samples, detects start and end of a measurement and tracks
// count, sum and first minimum. Depends on spc_pkg.
`default_nettype none

module spc_front #(
  parameter int MAX_SAMPLES = 400
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [spc_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic [spc_pkg::SAMPLE_W-1:0]   trigger_level,
  input  wire logic                           q_full,
  output logic                                q_push,
  output spc_pkg::meas_t                      q_rec
);

  logic                          meas_r, meas_nxt;
  logic [spc_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [spc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [spc_pkg::SAMPLE_W-1:0]  low_r, low_nxt;
  logic [spc_pkg::CNT_W-1:0]     lowpos_r, lowpos_nxt;

  logic                          accept;
  logic                          active;
  logic                          new_min;
  logic [spc_pkg::SAMPLE_W-1:0]  min_val;
  logic [spc_pkg::CNT_W-1:0]     min_pos;
  logic [spc_pkg::CNT_W-1:0]     cnt_inc;
  logic [spc_pkg::SUM_W-1:0]     sum_inc;
  logic                          hit_end;
  logic                          hit_limit;

  // A transaction is refused only while the measurement queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Per-sample updates of the running measurement.
  always_comb begin
    active    = meas_r || (in_sample < trigger_level);
    new_min   = (cnt_r == '0) || (in_sample < low_r);
    min_val   = new_min ? in_sample : low_r;
    min_pos   = new_min ? cnt_r : lowpos_r;
    cnt_inc   = cnt_r + 1'b1;
    sum_inc   = sum_r + spc_pkg::SUM_W'(in_sample);
    hit_end   = in_sample > trigger_level;
    hit_limit = cnt_inc >= spc_pkg::CNT_W'(MAX_SAMPLES);

    q_rec.ovf     = !hit_end && hit_limit;
    q_rec.min_val = min_val;
    q_rec.min_pos = min_pos;
    q_rec.count   = cnt_inc;
    q_rec.sum     = sum_inc;

    q_push     = 1'b0;
    meas_nxt   = meas_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    low_nxt    = low_r;
    lowpos_nxt = lowpos_r;

    if (accept && active) begin
      if (hit_end || hit_limit) begin
        // Measurement complete: hand it over and clear the tracker.
        q_push     = 1'b1;
        meas_nxt   = 1'b0;
        sum_nxt    = '0;
        cnt_nxt    = '0;
        low_nxt    = spc_pkg::SAMPLE_FULL;
        lowpos_nxt = '0;
      end else begin
        meas_nxt   = 1'b1;
        sum_nxt    = sum_inc;
        cnt_nxt    = cnt_inc;
        low_nxt    = min_val;
        lowpos_nxt = min_pos;
      end
    end
  end

  // Measurement state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r   <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
      low_r    <= spc_pkg::SAMPLE_FULL;
      lowpos_r <= '0;
    end else begin
      meas_r   <= meas_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      low_r    <= low_nxt;
      lowpos_r <= lowpos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spc_queue.sv =====
// Short queue of finished measurements between the front end and the classifier.
// Depends on spc_pkg.
`default_nettype none

module spc_queue (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire spc_pkg::meas_t wr_data,
  input  wire logic    pop,
  output spc_pkg::meas_t rd_data,
  output logic         empty,
  output logic         full
);

  spc_pkg::meas_t                 slot_r [spc_pkg::Q_DEPTH];
  logic [spc_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [spc_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [spc_pkg::Q_PTR_W:0]      fill_r, fill_nxt;

  assign empty   = (fill_r == '0);
  assign full    = (fill_r == (spc_pkg::Q_PTR_W + 1)'(spc_pkg::Q_DEPTH));
  assign rd_data = slot_r[rd_ptr_r];

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spc_back.sv =====
// Classifier: walks the profiles in order for one measurement and holds the
// result in an output register. Depends on spc_pkg.
`default_nettype none

module spc_back #(
  parameter int NUM_PROFILES = 4
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire spc_pkg::cls_cfg_t                           cfg,
  input  wire logic [NUM_PROFILES-1:0][spc_pkg::PROF_W-1:0] profiles,
  input  wire logic                                        q_empty,
  input  wire spc_pkg::meas_t                              q_data,
  output logic                                             q_pop,
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output spc_pkg::res_t                                    result
);

  spc_pkg::back_state_t          state_r, state_nxt;
  spc_pkg::meas_t                rec_r, rec_nxt;
  spc_pkg::res_t                 res_r, res_nxt;
  logic [spc_pkg::PIDX_W-1:0]    idx_r, idx_nxt;
  logic [spc_pkg::PIDX_W-1:0]    last_r, last_nxt;
  logic [spc_pkg::SUM_W-1:0]     target_r, target_nxt;
  logic [spc_pkg::SUM_W-1:0]     limit_r, limit_nxt;

  logic [spc_pkg::PCOUNT_W-1:0]  n_used;
  logic [spc_pkg::PROF_W-1:0]    prof_sel;
  spc_pkg::prof_t                pf;
  logic [spc_pkg::SUM_W-1:0]     diff;
  logic                          avg_ok;
  logic [spc_pkg::SAMPLE_W:0]    depth_limit;
  logic                          hole_ok;

  assign out_valid = (state_r == spc_pkg::B_OUT);
  assign result    = res_r;

  // Profiles beyond the built number are never checked.
  assign n_used = (cfg.count > spc_pkg::PCOUNT_W'(NUM_PROFILES))
                  ? spc_pkg::PCOUNT_W'(NUM_PROFILES) : cfg.count;

  // Select the profile under test.
  always_comb begin
    prof_sel = '0;
    for (int i = 0; i < NUM_PROFILES; i++) begin
      if (idx_r == spc_pkg::PIDX_W'(i)) begin
        prof_sel = profiles[i];
      end
    end
  end

  assign pf = spc_pkg::unpack_profile(prof_sel);

  // Average test against the registered products, and the hole test.
  assign diff        = (rec_r.sum > target_r) ? (rec_r.sum - target_r)
                                              : (target_r - rec_r.sum);
  assign avg_ok      = diff <= limit_r;
  assign depth_limit = {1'b0, pf.hole_min} + {1'b0, cfg.tol};
  assign hole_ok     = ({1'b0, rec_r.min_val} <= depth_limit) &&
                       (rec_r.min_pos >= pf.hole_start) &&
                       (rec_r.min_pos <= pf.hole_stop);

  // Profile walk sequencer.
  always_comb begin
    state_nxt  = state_r;
    rec_nxt    = rec_r;
    res_nxt    = res_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    target_nxt = target_r;
    limit_nxt  = limit_r;
    q_pop      = 1'b0;

    case (state_r)
      spc_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop           = 1'b1;
          rec_nxt         = q_data;
          idx_nxt         = '0;
          last_nxt        = spc_pkg::PIDX_W'(n_used - 1'b1);
          res_nxt.matched = 1'b0;
          res_nxt.pidx    = '0;
          res_nxt.ovf     = q_data.ovf;
          res_nxt.min_val = q_data.min_val;
          res_nxt.min_pos = q_data.min_pos;
          res_nxt.count   = q_data.count;
          state_nxt       = (n_used == '0) ? spc_pkg::B_OUT : spc_pkg::B_MUL;
        end
      end
      spc_pkg::B_MUL: begin
        target_nxt = spc_pkg::SUM_W'(pf.avg) * spc_pkg::SUM_W'(rec_r.count);
        limit_nxt  = spc_pkg::SUM_W'(cfg.tol) * spc_pkg::SUM_W'(rec_r.count);
        state_nxt  = spc_pkg::B_CMP;
      end
      spc_pkg::B_CMP: begin
        if (!avg_ok) begin
          if (idx_r == last_r) begin
            state_nxt = spc_pkg::B_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = spc_pkg::B_MUL;
          end
        end else begin
          // The first profile whose average fits decides the result.
          if (!pf.has_hole || hole_ok) begin
            res_nxt.matched = 1'b1;
            res_nxt.pidx    = idx_r;
          end
          state_nxt = spc_pkg::B_OUT;
        end
      end
      spc_pkg::B_OUT: begin
        if (!out_stall) begin
          state_nxt = spc_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = spc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spc_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working and result registers carry no reset.
  always_ff @(posedge clk) begin
    rec_r    <= rec_nxt;
    res_r    <= res_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
    target_r <= target_nxt;
    limit_r  <= limit_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sensor_profile_classifier.sv =====
// Sensor profile classifier: one sample is taken per cycle unless the two-entry queue is full.
// With the classifier idle, the ending sample's measurement is queued and popped, then each
// profile walked takes a multiply step and a compare step before out_valid rises.
// The next measurement is popped only after the result has left the output state.
// Reset is synchronous, active low: configuration registers return to defaults, any open
// measurement and any queued measurement are dropped; no clearing pass is needed.
`default_nettype none
`include "sensor_profile_classifier_macros.svh"

module sensor_profile_classifier #(
  parameter int MAX_SAMPLES  = 400,
  parameter int NUM_PROFILES = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Sample channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [spc_pkg::SAMPLE_W-1:0]    in_sample,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_matched,
  output logic [spc_pkg::PIDX_W-1:0]           out_profile_index,
  output logic                                 out_overflow,
  output logic [spc_pkg::SAMPLE_W-1:0]         out_minimum_value,
  output logic [spc_pkg::CNT_W-1:0]            out_minimum_position,
  output logic [spc_pkg::CNT_W-1:0]            out_sample_count,
  // Register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [spc_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [spc_pkg::PDATA_W-1:0]     pwdata,
  output logic [spc_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic [spc_pkg::SAMPLE_W-1:0]                trigger_r;
  logic [spc_pkg::SAMPLE_W-1:0]                tol_r;
  logic [spc_pkg::PCOUNT_W-1:0]                pcount_r;
  logic [NUM_PROFILES-1:0][spc_pkg::PROF_W-1:0] profiles_r;

  logic                                        wr_en;
  logic [spc_pkg::REG_IDX_W-1:0]               reg_sel;
  spc_pkg::cls_cfg_t                           cls_cfg;

  logic                                        q_push;
  logic                                        q_pop;
  logic                                        q_empty;
  logic                                        q_full;
  spc_pkg::meas_t                              q_wr;
  spc_pkg::meas_t                              q_rd;
  spc_pkg::res_t                               result;

  // Register port decode; every transaction completes at once.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[spc_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r  <= spc_pkg::TRIGGER_RESET;
      tol_r      <= spc_pkg::TOLERANCE_RESET;
      pcount_r   <= '0;
      profiles_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        spc_pkg::REG_TRIGGER:   trigger_r <= pwdata[spc_pkg::SAMPLE_W-1:0];
        spc_pkg::REG_TOLERANCE: tol_r     <= pwdata[spc_pkg::SAMPLE_W-1:0];
        spc_pkg::REG_PCOUNT:    pcount_r  <= pwdata[spc_pkg::PCOUNT_W-1:0];
        default: begin
          for (int i = 0; i < NUM_PROFILES; i++) begin
            if (reg_sel == spc_pkg::REG_PROFILE0 + spc_pkg::REG_IDX_W'(i)) begin
              profiles_r[i] <= pwdata[spc_pkg::PROF_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (reg_sel)
      spc_pkg::REG_TRIGGER:   prdata = spc_pkg::PDATA_W'(trigger_r);
      spc_pkg::REG_TOLERANCE: prdata = spc_pkg::PDATA_W'(tol_r);
      spc_pkg::REG_PCOUNT:    prdata = spc_pkg::PDATA_W'(pcount_r);
      default: begin
        for (int i = 0; i < NUM_PROFILES; i++) begin
          if (reg_sel == spc_pkg::REG_PROFILE0 + spc_pkg::REG_IDX_W'(i)) begin
            prdata = spc_pkg::PDATA_W'(profiles_r[i]);
          end
        end
      end
    endcase
  end

  assign cls_cfg.tol   = tol_r;
  assign cls_cfg.count = pcount_r;

  // Measurement front end.
  spc_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .trigger_level (trigger_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_rec         (q_wr)
  );

  // Queue of finished measurements.
  spc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Profile classifier.
  spc_back #(
    .NUM_PROFILES (NUM_PROFILES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cls_cfg),
    .profiles  (profiles_r),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_matched          = result.matched;
  assign out_profile_index    = result.pidx;
  assign out_overflow         = result.ovf;
  assign out_minimum_value    = result.min_val;
  assign out_minimum_position = result.min_pos;
  assign out_sample_count     = result.count;

  // Design checks.
  `SPC_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "measurement pushed into a full queue")
  `SPC_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty, "pushed measurement was lost")
  `SPC_ASSERT_NOW(a_min_inside, out_valid, out_minimum_position < out_sample_count,
                  "minimum position outside the measurement")
  `SPC_ASSERT_NOW(a_unknown_index, out_valid && !out_matched, out_profile_index == '0,
                  "unknown part reported with a profile index")

endmodule

`default_nettype wire

// ===== bench/sensor_profile_classifier_tb.sv =====
// Self-checking testbench for the sensor profile classifier: directed, corner and random
// sample streams checked against an in-bench predictor. Depends on spc_pkg and the block.
`default_nettype none

module sensor_profile_classifier_tb;

  localparam int MAX_SAMPLES       = 400;
  localparam int NUM_PROFILES      = 4;
  localparam int ITEM_TARGET       = 1700;
  localparam int TAIL_ITEMS        = 1213;
  localparam int SETTLE_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT    = 3000;
  localparam int LONG_HOLD_CYCLES  = 400;
  localparam int LONG_HOLD_AFTER   = 4;
  localparam int LONG_HOLD_BACKLOG = 40;
  localparam logic [spc_pkg::SAMPLE_W-1:0] FULL_SCALE = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [spc_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_matched;
  logic [spc_pkg::PIDX_W-1:0] out_profile_index;
  logic out_overflow;
  logic [spc_pkg::SAMPLE_W-1:0] out_minimum_value;
  logic [spc_pkg::CNT_W-1:0] out_minimum_position;
  logic [spc_pkg::CNT_W-1:0] out_sample_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [spc_pkg::PADDR_W-1:0] paddr = '0;
  logic [spc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [spc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // Register copies used by the predictor.
  logic [spc_pkg::SAMPLE_W-1:0] lvl_trigger = spc_pkg::TRIGGER_RESET;
  logic [spc_pkg::SAMPLE_W-1:0] lvl_tol = spc_pkg::TOLERANCE_RESET;
  logic [spc_pkg::PCOUNT_W-1:0] prof_count = '0;
  logic [spc_pkg::PROF_W-1:0] prof_reg [NUM_PROFILES] = '{default: '0};

  // Measurement state of the predictor.
  bit meas_active = 1'b0;
  int unsigned meas_sum = 0;
  int unsigned meas_count = 0;
  logic [spc_pkg::SAMPLE_W-1:0] meas_low = FULL_SCALE;
  int unsigned meas_low_pos = 0;

  logic [spc_pkg::SAMPLE_W-1:0] sample_backlog [$];
  spc_pkg::res_t expected_verdicts [$];
  spc_pkg::res_t oldest_verdict;

  int mismatches = 0;
  int verdicts_checked = 0;
  int samples_sent = 0;
  int items_queued = 0;
  int reg_writes = 0;
  int settings_run = 0;

  // Sender burst shaping.
  int burst_left = 1;
  int gap_left = 0;

  // Receiver stall shaping.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int rx_count = 0;
  bit long_hold_done = 1'b0;

  int idle_cycles = 0;

  int directed_reset [11] = '{2048, 4095, 0, 2048, 4095, 2047, 5, 5, 1, 1, 2049};
  int directed_prof [12] = '{600, 600, 200, 600, 600, 2001, 200, 600, 600, 600, 600, 2001};

  always #5 clk = ~clk;

  sensor_profile_classifier DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_matched         (out_matched),
    .out_profile_index   (out_profile_index),
    .out_overflow        (out_overflow),
    .out_minimum_value   (out_minimum_value),
    .out_minimum_position(out_minimum_position),
    .out_sample_count    (out_sample_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Append one sample to the pending stimulus and count it.
  task automatic backlog_add(input logic [spc_pkg::SAMPLE_W-1:0] s);
    sample_backlog.insert(sample_backlog.size(), s);
    items_queued++;
  endtask

  // Advance the measurement by one sample and queue the classification it causes, if any.
  task automatic track_sample(input logic [spc_pkg::SAMPLE_W-1:0] s);
    int unsigned n, i, target, diff, avg, hmin, hstart, hstop;
    bit ended, stop_walk;
    logic [spc_pkg::PROF_W-1:0] p;
    spc_pkg::res_t verdict;
    ended = 1'b0;
    stop_walk = 1'b0;
    verdict = '0;
    if (!meas_active && s < lvl_trigger) meas_active = 1'b1;
    if (meas_active) begin
      if (meas_count == 0 || s < meas_low) begin
        meas_low = s;
        meas_low_pos = meas_count;
      end
      meas_sum += s;
      meas_count++;
      if (s > lvl_trigger) begin
        ended = 1'b1;
      end else if (meas_count >= MAX_SAMPLES) begin
        ended = 1'b1;
        verdict.ovf = 1'b1;
      end
      if (ended) begin
        verdict.min_val = meas_low;
        verdict.min_pos = spc_pkg::CNT_W'(meas_low_pos);
        verdict.count = spc_pkg::CNT_W'(meas_count);
        n = (prof_count > NUM_PROFILES) ? NUM_PROFILES : prof_count;
        // Walk the profiles in order; the first one whose average passes decides.
        for (i = 0; i < n && !stop_walk; i++) begin
          p = prof_reg[i];
          avg = p[12:1];
          hmin = p[24:13];
          hstart = p[33:25];
          hstop = p[42:34];
          target = avg * meas_count;
          diff = (meas_sum > target) ? meas_sum - target : target - meas_sum;
          if (diff <= lvl_tol * meas_count) begin
            stop_walk = 1'b1;
            if (!p[0] || (meas_low <= hmin + lvl_tol &&
                          meas_low_pos >= hstart && meas_low_pos <= hstop)) begin
              verdict.matched = 1'b1;
              verdict.pidx = spc_pkg::PIDX_W'(i);
            end
          end
        end
        expected_verdicts.insert(expected_verdicts.size(), verdict);
        meas_active = 1'b0;
        meas_sum = 0;
        meas_count = 0;
        meas_low = FULL_SCALE;
        meas_low_pos = 0;
      end
    end
  endtask

  // Register write: setup cycle, then access cycle; the copy follows the block.
  task automatic reg_write(input logic [spc_pkg::REG_IDX_W-1:0] code,
                           input logic [spc_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {code, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (code == spc_pkg::REG_TRIGGER) begin
      lvl_trigger = value[spc_pkg::SAMPLE_W-1:0];
    end else if (code == spc_pkg::REG_TOLERANCE) begin
      lvl_tol = value[spc_pkg::SAMPLE_W-1:0];
    end else if (code == spc_pkg::REG_PCOUNT) begin
      prof_count = value[spc_pkg::PCOUNT_W-1:0];
    end else if (code >= spc_pkg::REG_PROFILE0) begin
      prof_reg[code - spc_pkg::REG_PROFILE0] = value[spc_pkg::PROF_W-1:0];
    end
    reg_writes++;
  endtask

  // Wait until every sample is taken and every classification has come out.
  task automatic settle();
    while (sample_backlog.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Finish any open measurement so the next settings start from idle.
  task automatic close_phase();
    int k;
    settle();
    if (meas_active) begin
      if (lvl_trigger < FULL_SCALE) begin
        backlog_add(FULL_SCALE);
      end else begin
        for (k = meas_count; k < MAX_SAMPLES; k++) backlog_add('0);
      end
      settle();
    end
    settings_run++;
  endtask

  // One part passing the sensor: a level with noise, an optional dip, and an optional end sample.
  task automatic queue_part(input int len, input int level, input int noise, input int dip_pos,
                            input int dip_val, input bit close);
    int i, v;
    for (i = 0; i < len; i++) begin
      if (i == dip_pos) v = dip_val;
      else v = level + int'($urandom_range(0, 2 * noise)) - noise;
      if (v < 0) v = 0;
      if (v > int'(lvl_trigger)) v = lvl_trigger;
      if (i == 0 && v >= int'(lvl_trigger) && lvl_trigger > 0) v = lvl_trigger - 1;
      backlog_add(spc_pkg::SAMPLE_W'(v));
    end
    if (close && lvl_trigger < FULL_SCALE)
      backlog_add(spc_pkg::SAMPLE_W'($urandom_range(4095, lvl_trigger + 1)));
  endtask

  // Random settings, with profiles mostly well-formed so parts can match them.
  task automatic random_setup();
    int trig, tol, avg, hmin, hstart, hstop, j;
    logic [63:0] wide;
    logic [spc_pkg::PROF_W-1:0] p;
    case ($urandom_range(0, 9))
      0: trig = 4095;
      1: trig = $urandom_range(1, 300);
      default: trig = $urandom_range(800, 4000);
    endcase
    case ($urandom_range(0, 9))
      0: tol = 0;
      1: tol = 4095;
      default: tol = $urandom_range(10, 400);
    endcase
    reg_write(spc_pkg::REG_TRIGGER, 64'(trig));
    reg_write(spc_pkg::REG_TOLERANCE, 64'(tol));
    reg_write(spc_pkg::REG_PCOUNT, 64'($urandom_range(0, 7)));
    for (j = 0; j < NUM_PROFILES; j++) begin
      if ($urandom_range(0, 7) == 0) begin
        wide = {$urandom, $urandom};
        p = wide[spc_pkg::PROF_W-1:0];
      end else begin
        avg = $urandom_range(0, (trig > 0) ? trig - 1 : 0);
        hmin = $urandom_range(0, avg);
        hstart = $urandom_range(0, 30);
        hstop = hstart + $urandom_range(0, 40);
        p = {9'(hstop), 9'(hstart), 12'(hmin), 12'(avg), 1'($urandom_range(0, 1))};
      end
      reg_write(spc_pkg::REG_PROFILE0 + spc_pkg::REG_IDX_W'(j), 64'(p));
    end
  endtask

  // Driver: bursts of transactions with random gaps; a stalled payload is held.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_sample(in_sample);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_sample <= sample_backlog.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall patterns, plus one long hold while samples keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_count++;
      if (!long_hold_done && rx_count >= LONG_HOLD_AFTER && in_valid &&
          sample_backlog.size() > LONG_HOLD_BACKLOG) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Monitor: each result transaction is checked against the oldest expected verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none expected, actual count %0d",
                 $time, out_sample_count);
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        compare_field("matched", 32'(oldest_verdict.matched), 32'(out_matched));
        compare_field("profile_index", 32'(oldest_verdict.pidx), 32'(out_profile_index));
        compare_field("overflow", 32'(oldest_verdict.ovf), 32'(out_overflow));
        compare_field("minimum_value", 32'(oldest_verdict.min_val), 32'(out_minimum_value));
        compare_field("minimum_position", 32'(oldest_verdict.min_pos),
                      32'(out_minimum_position));
        compare_field("sample_count", 32'(oldest_verdict.count), 32'(out_sample_count));
      end
      verdicts_checked++;
    end
  end

  // Watchdog: too long without any transaction on any port ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d verdicts still pending", $time,
               expected_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int i, parts, kind, j, len, pos, dipv, avg, hmin, hstart, hstop;
    logic [spc_pkg::PROF_W-1:0] p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: level equal to the trigger, idle samples, no profiles in use.
    foreach (directed_reset[di]) backlog_add(spc_pkg::SAMPLE_W'(directed_reset[di]));
    close_phase();

    // Each profile outcome: average miss, hole match, hole miss stopping the walk.
    reg_write(spc_pkg::REG_TRIGGER, 64'd2000);
    reg_write(spc_pkg::REG_TOLERANCE, 64'd400);
    reg_write(spc_pkg::REG_PCOUNT, 64'd4);
    reg_write(spc_pkg::REG_PROFILE0, 64'({9'd0, 9'd0, 12'd0, 12'd3000, 1'b0}));
    reg_write(spc_pkg::REG_PROFILE0 + 3'd1, 64'({9'd4, 9'd2, 12'd200, 12'd600, 1'b1}));
    reg_write(spc_pkg::REG_PROFILE0 + 3'd2, 64'({9'd0, 9'd0, 12'd0, 12'd600, 1'b0}));
    reg_write(spc_pkg::REG_PROFILE0 + 3'd3, 64'({spc_pkg::PROF_W{1'b1}}));
    foreach (directed_prof[di]) backlog_add(spc_pkg::SAMPLE_W'(directed_prof[di]));
    close_phase();

    // Many short parts at once; the receiver holds off so the block fills and stalls.
    repeat (30) queue_part(1, $urandom_range(0, 4095), 0, -1, 0, 1'b1);
    close_phase();

    // Random settings, each followed by a mix of parts, noise and broken sequences.
    while (items_queued < ITEM_TARGET - TAIL_ITEMS) begin
      random_setup();
      parts = $urandom_range(2, 8);
      for (i = 0; i < parts; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          j = $urandom_range(0, NUM_PROFILES - 1);
          p = prof_reg[j];
          avg = p[12:1];
          hmin = p[24:13];
          hstart = p[33:25];
          hstop = p[42:34];
          len = $urandom_range(1, 60);
          pos = -1;
          dipv = 0;
          if (p[0]) begin
            if (hstart < 60 && len <= hstart) len = hstart + 1 + $urandom_range(0, 10);
            if (hstop >= hstart && $urandom_range(0, 4) != 0)
              pos = hstart + $urandom_range(0, hstop - hstart);
            else
              pos = $urandom_range(0, len - 1);
            dipv = hmin + int'($urandom_range(0, 20)) - 10;
          end
          queue_part(len, avg, $urandom_range(0, 15), pos, dipv, 1'b1);
          // Idle samples at or above the level between parts.
          if ($urandom_range(0, 2) == 0 && lvl_trigger < FULL_SCALE)
            repeat ($urandom_range(1, 5))
              backlog_add(spc_pkg::SAMPLE_W'($urandom_range(4095, lvl_trigger)));
        end else if (kind < 80) begin
          // Back-to-back two-sample parts fill the measurement queue.
          repeat ($urandom_range(5, 15))
            queue_part(1, $urandom_range(0, 4095), 0, -1, 0, 1'b1);
        end else if (kind < 95) begin
          len = $urandom_range(5, 30);
          repeat (len) backlog_add(spc_pkg::SAMPLE_W'($urandom));
        end else begin
          queue_part($urandom_range(300, 420), $urandom_range(0, 4095),
                     $urandom_range(0, 30), -1, 0, 1'($urandom_range(0, 1)));
        end
      end
      close_phase();
    end

    // Trigger at zero: nothing can start a measurement.
    reg_write(spc_pkg::REG_TRIGGER, 64'd0);
    reg_write(spc_pkg::REG_TOLERANCE, 64'd4095);
    reg_write(spc_pkg::REG_PCOUNT, 64'd7);
    reg_write(spc_pkg::REG_PROFILE0, 64'({spc_pkg::PROF_W{1'b1}}));
    reg_write(spc_pkg::REG_PROFILE0 + 3'd1, 64'd0);
    repeat (12) backlog_add(spc_pkg::SAMPLE_W'($urandom));
    close_phase();

    // Trigger at full scale: only the sample limit ends a measurement.
    reg_write(spc_pkg::REG_TRIGGER, 64'd4095);
    reg_write(spc_pkg::REG_TOLERANCE, 64'd0);
    reg_write(spc_pkg::REG_PCOUNT, 64'd5);
    backlog_add('0);
    repeat (MAX_SAMPLES - 1) backlog_add(spc_pkg::SAMPLE_W'($urandom));
    close_phase();

    // End sample landing exactly on the limit, then a part that runs into it.
    reg_write(spc_pkg::REG_TRIGGER, 64'd2000);
    reg_write(spc_pkg::REG_TOLERANCE, 64'd4095);
    queue_part(MAX_SAMPLES - 1, 1000, 50, -1, 0, 1'b1);
    queue_part(MAX_SAMPLES, 1000, 50, -1, 0, 1'b0);
    backlog_add(spc_pkg::SAMPLE_W'(3000));
    close_phase();

    if (expected_verdicts.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected verdicts never arrived", $time, expected_verdicts.size());
    end
    $display("Sent %0d samples under %0d settings with %0d register writes.",
             samples_sent, settings_run, reg_writes);
    $display("Compared %0d classification results, %0d mismatches.",
             verdicts_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
